// ----- src/slrsk_pkg.sv -----
// Package for the split link receive sequence and key state checker.
// Holds sizes, result and verdict codes and the front-to-back command type.
// No dependencies.
package slrsk_pkg;

    localparam int SOURCES       = 2;
    localparam int KEY_POSITIONS = 32;
    localparam int PEER_W        = 3;
    localparam int POS_W         = 6;
    localparam int PEERS_W       = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int KP_W          = $clog2(KEY_POSITIONS);

    typedef enum logic [1:0] {
        RK_RELEASE    = 2'd0,
        RK_VERDICT    = 2'd1,
        RK_DISCONNECT = 2'd2
    } rkind_t;

    typedef enum logic [2:0] {
        VD_FORWARD  = 3'd0,
        VD_ACCEPTED = 3'd1,
        VD_DUP      = 3'd2,
        VD_OOO      = 3'd3,
        VD_BAD_SRC  = 3'd4,
        VD_BAD_PIPE = 3'd5
    } verdict_t;

    // Command handed from front to back
    typedef enum logic [1:0] {
        OP_BAD_SRC  = 2'd0,
        OP_BAD_PIPE = 2'd1,
        OP_DISC     = 2'd2,
        OP_PACKET   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [PEER_W-1:0]  peer;
        logic [31:0]        session_tag;
        logic [31:0]        sequence_req;
        logic               fwd;       // app event and transport active
        logic               key_track; // key event within tracked range
        logic [POS_W-1:0]   key_pos;
        logic               pressed;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RELEASE,
        ST_SEQ,
        ST_KEY,
        ST_EMIT
    } bst_t;

endpackage

// ----- src/split_link_rx_sequence_keystate.sv -----
// Top level of the split link receive sequence and key state checker.
// Depends on slrsk_pkg, slrsk_front and slrsk_back.
//
//   channel   direction  handshake          contents
//   s_*       in         s_valid/s_ready    packet header or disconnect notice
//   m_*       out        m_valid/m_ready    release, verdict or disconnect done
//   cfg_*     in         cfg_we             transport_active
//
// A packet header steps the back sequencer through check, sequence, key and emit;
// a bad source or wrong pipe gets its verdict from the check step. A session change
// first walks the key bitmap to release held keys, and a disconnect walks it and
// then emits disconnect done; a released key does not slow the walk unless the
// result is stalled. A two-entry queue lets the front take headers while the
// back works. Reset clears all per-peer state at once; transport_active
// resets to 1. A stalled result holds the sequencer at its emitting step.
module split_link_rx_sequence_keystate (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_wire_source,
    input  logic [2:0]  s_pipe,
    input  logic [31:0] s_session_tag,
    input  logic [31:0] s_sequence_req,
    input  logic        s_is_app_event,
    input  logic        s_is_key_event,
    input  logic [7:0]  s_key_position,
    input  logic        s_pressed,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [2:0]  m_peer,
    output logic [5:0]  m_release_position,
    output logic [2:0]  m_verdict,
    output logic [31:0] m_gap,
    output logic [31:0] m_received_count,
    output logic [31:0] m_gap_total,
    output logic [31:0] m_duplicate_count,
    output logic [31:0] m_reorder_count,
    output logic [31:0] m_session_change_count,
    output logic        m_last
);
    import slrsk_pkg::*;

    logic active_reg;
    logic q_valid, q_ready;
    cmd_t q_cmd;

    // Hold the configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) active_reg <= 1'b1;
        else if (cfg_we) active_reg <= cfg_wdata;
    end

    slrsk_front u_front (
        .aclk, .aresetn,
        .transport_active(active_reg),
        .s_valid, .s_ready, .s_kind, .s_wire_source, .s_pipe, .s_session_tag,
        .s_sequence_req, .s_is_app_event, .s_is_key_event, .s_key_position,
        .s_pressed,
        .q_valid, .q_ready, .q_cmd
    );

    slrsk_back u_back (
        .aclk, .aresetn,
        .q_valid, .q_ready, .q_cmd,
        .m_valid, .m_ready, .m_result_kind, .m_peer, .m_release_position,
        .m_verdict, .m_gap, .m_received_count, .m_gap_total,
        .m_duplicate_count, .m_reorder_count, .m_session_change_count, .m_last
    );
endmodule

// ----- src/slrsk_front.sv -----
// Front part: accepts headers, classifies source and pipe, queues commands.
// Depends on slrsk_pkg.
module slrsk_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                transport_active,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  logic [7:0]          s_wire_source,
    input  logic [2:0]          s_pipe,
    input  logic [31:0]         s_session_tag,
    input  logic [31:0]         s_sequence_req,
    input  logic                s_is_app_event,
    input  logic                s_is_key_event,
    input  logic [7:0]          s_key_position,
    input  logic                s_pressed,
    output logic                q_valid,
    input  logic                q_ready,
    output slrsk_pkg::cmd_t     q_cmd
);
    import slrsk_pkg::*;

    // Two-entry queue
    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    cmd_t       cmd;
    logic       push, pop;

    // Classify the incoming header
    always_comb begin
        cmd = '0;
        cmd.peer = PEER_W'(s_wire_source - 8'd1);
        cmd.session_tag = s_session_tag;
        cmd.sequence_req = s_sequence_req;
        cmd.fwd = s_is_app_event & transport_active;
        cmd.key_track = s_is_key_event && (s_key_position < 8'(KEY_POSITIONS));
        cmd.key_pos = s_key_position[POS_W-1:0];
        cmd.pressed = s_pressed;
        if (s_wire_source == 8'd0 || s_wire_source > 8'(SOURCES)) begin
            cmd.op = OP_BAD_SRC;
            cmd.peer = '0;
        end else if (s_kind) begin
            cmd.op = OP_DISC;
        end else if ({5'd0, s_pipe} != s_wire_source) begin
            cmd.op = OP_BAD_PIPE;
        end else begin
            cmd.op = OP_PACKET;
        end
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid & s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid & q_ready;
    assign q_cmd   = mem_reg[rd_ptr_reg];

    // Store transfer
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= cmd;
    end

    // Advance pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ----- src/slrsk_back.sv -----
// Back part: per-peer session, sequence, counters and key bitmap; emits results.
// Depends on slrsk_pkg.
module slrsk_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_valid,
    output logic                    q_ready,
    input  slrsk_pkg::cmd_t         q_cmd,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_result_kind,
    output logic [2:0]              m_peer,
    output logic [5:0]              m_release_position,
    output logic [2:0]              m_verdict,
    output logic [31:0]             m_gap,
    output logic [31:0]             m_received_count,
    output logic [31:0]             m_gap_total,
    output logic [31:0]             m_duplicate_count,
    output logic [31:0]             m_reorder_count,
    output logic [31:0]             m_session_change_count,
    output logic                    m_last
);
    import slrsk_pkg::*;

    // Per-peer state
    logic        ses_known_reg  [SOURCES];
    logic        seq_known_reg  [SOURCES];
    logic [31:0] cur_ses_reg    [SOURCES];
    logic [31:0] last_seq_reg   [SOURCES];
    logic [31:0] rx_reg         [SOURCES];
    logic [31:0] gtot_reg       [SOURCES];
    logic [31:0] dup_reg        [SOURCES];
    logic [31:0] ooo_reg        [SOURCES];
    logic [31:0] sesc_reg       [SOURCES];
    logic [KEY_POSITIONS-1:0] held_reg [SOURCES];

    bst_t                 st_reg, st_next;
    cmd_t                 cmd_reg;
    logic [KP_W:0]        walk_reg, walk_next;
    logic [31:0]          gap_reg, gap_next;
    verdict_t             vd_reg, vd_next;

    // Output register
    logic                 ov_reg, ov_next;
    logic [1:0]           ork_reg, ork_next;
    logic [2:0]           opeer_reg, opeer_next;
    logic [5:0]           opos_reg, opos_next;
    logic [2:0]           ovd_reg, ovd_next;
    logic [31:0]          ogap_reg, ogap_next;
    logic                 ocnt_next, ocnt_reg;
    logic                 olast_reg, olast_next;

    logic [PEERS_W-1:0]   p;
    logic                 out_free;
    logic                 held_bit;
    logic                 cnt_update;

    assign p        = cmd_reg.peer[PEERS_W-1:0];
    assign out_free = !ov_reg || m_ready;
    assign held_bit = held_reg[p][walk_reg[KP_W-1:0]];

    // Control sequencer
    always_comb begin
        st_next    = st_reg;
        walk_next  = walk_reg;
        gap_next   = gap_reg;
        vd_next    = vd_reg;
        q_ready    = 1'b0;
        ov_next    = ov_reg && !m_ready;
        ork_next   = ork_reg;
        opeer_next = opeer_reg;
        opos_next  = opos_reg;
        ovd_next   = ovd_reg;
        ogap_next  = ogap_reg;
        ocnt_next  = ocnt_reg;
        olast_next = olast_reg;
        cnt_update = 1'b0;
        unique case (st_reg)
            ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) st_next = ST_CHECK;
            end
            ST_CHECK: begin
                walk_next = '0;
                unique case (cmd_reg.op)
                    OP_BAD_SRC, OP_BAD_PIPE: begin
                        if (out_free) begin
                            ov_next = 1'b1; ork_next = RK_VERDICT;
                            opeer_next = cmd_reg.peer; opos_next = '0;
                            ovd_next = (cmd_reg.op == OP_BAD_SRC) ? VD_BAD_SRC : VD_BAD_PIPE;
                            ogap_next = '0; ocnt_next = 1'b0; olast_next = 1'b1;
                            st_next = ST_IDLE;
                        end
                    end
                    OP_DISC: st_next = ST_RELEASE;
                    OP_PACKET: begin
                        if (ses_known_reg[p] && cur_ses_reg[p] != cmd_reg.session_tag)
                            st_next = ST_RELEASE;
                        else
                            st_next = ST_SEQ;
                    end
                    default: st_next = ST_IDLE;
                endcase
            end
            ST_RELEASE: begin
                if (walk_reg == (KP_W+1)'(KEY_POSITIONS)) begin
                    if (cmd_reg.op == OP_DISC) begin
                        if (out_free) begin
                            ov_next = 1'b1; ork_next = RK_DISCONNECT;
                            opeer_next = cmd_reg.peer; opos_next = '0; ovd_next = '0;
                            ogap_next = '0; ocnt_next = 1'b0; olast_next = 1'b1;
                            st_next = ST_IDLE;
                        end
                    end else begin
                        st_next = ST_SEQ;
                    end
                end else if (!held_bit) begin
                    walk_next = walk_reg + 1'b1;
                end else if (out_free) begin
                    ov_next = 1'b1; ork_next = RK_RELEASE;
                    opeer_next = cmd_reg.peer; opos_next = POS_W'(walk_reg);
                    ovd_next = '0; ogap_next = '0; ocnt_next = 1'b0; olast_next = 1'b0;
                    walk_next = walk_reg + 1'b1;
                end
            end
            ST_SEQ: begin
                gap_next = '0;
                cnt_update = 1'b1;
                if (!seq_known_reg[p]) begin
                    vd_next = cmd_reg.fwd ? VD_FORWARD : VD_ACCEPTED;
                end else if (cmd_reg.sequence_req == last_seq_reg[p]) begin
                    vd_next = VD_DUP;
                end else if (cmd_reg.sequence_req > last_seq_reg[p]) begin
                    gap_next = cmd_reg.sequence_req - last_seq_reg[p] - 32'd1;
                    vd_next = cmd_reg.fwd ? VD_FORWARD : VD_ACCEPTED;
                end else begin
                    vd_next = VD_OOO;
                end
                st_next = ST_KEY;
            end
            ST_KEY: begin
                // Inject a release when a held key is pressed again in a forwarded event
                if (vd_reg == VD_FORWARD && cmd_reg.key_track && cmd_reg.pressed
                    && held_reg[p][cmd_reg.key_pos[KP_W-1:0]]) begin
                    if (out_free) begin
                        ov_next = 1'b1; ork_next = RK_RELEASE;
                        opeer_next = cmd_reg.peer; opos_next = cmd_reg.key_pos;
                        ovd_next = '0; ogap_next = '0; ocnt_next = 1'b0; olast_next = 1'b0;
                        st_next = ST_EMIT;
                    end
                end else begin
                    st_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    ov_next = 1'b1; ork_next = RK_VERDICT;
                    opeer_next = cmd_reg.peer; opos_next = '0; ovd_next = vd_reg;
                    ogap_next = gap_reg; ocnt_next = 1'b1; olast_next = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // Hold control and output state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            ov_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_reg == ST_IDLE && q_valid) cmd_reg <= q_cmd;
        walk_reg  <= walk_next;
        gap_reg   <= gap_next;
        vd_reg    <= vd_next;
        ork_reg   <= ork_next;
        opeer_reg <= opeer_next;
        opos_reg  <= opos_next;
        ovd_reg   <= ovd_next;
        ogap_reg  <= ogap_next;
        ocnt_reg  <= ocnt_next;
        olast_reg <= olast_next;
    end

    // Update per-peer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SOURCES; i++) begin
                ses_known_reg[i] <= 1'b0; seq_known_reg[i] <= 1'b0;
                cur_ses_reg[i] <= '0; last_seq_reg[i] <= '0;
                rx_reg[i] <= '0; gtot_reg[i] <= '0; dup_reg[i] <= '0;
                ooo_reg[i] <= '0; sesc_reg[i] <= '0; held_reg[i] <= '0;
            end
        end else begin
            unique case (st_reg)
                ST_CHECK: begin
                    if (cmd_reg.op == OP_DISC) begin
                        seq_known_reg[p] <= 1'b0;
                    end else if (cmd_reg.op == OP_PACKET &&
                                 (!ses_known_reg[p] ||
                                  cur_ses_reg[p] != cmd_reg.session_tag)) begin
                        if (ses_known_reg[p]) sesc_reg[p] <= sesc_reg[p] + 32'd1;
                        ses_known_reg[p] <= 1'b1;
                        seq_known_reg[p] <= 1'b0;
                        cur_ses_reg[p]   <= cmd_reg.session_tag;
                    end
                end
                ST_RELEASE: begin
                    if (walk_reg == (KP_W+1)'(KEY_POSITIONS)) held_reg[p] <= '0;
                end
                ST_SEQ: begin
                    if (cnt_update) begin
                        rx_reg[p] <= rx_reg[p] + 32'd1;
                        if (!seq_known_reg[p]) begin
                            seq_known_reg[p] <= 1'b1;
                            last_seq_reg[p]  <= cmd_reg.sequence_req;
                        end else if (cmd_reg.sequence_req == last_seq_reg[p]) begin
                            dup_reg[p] <= dup_reg[p] + 32'd1;
                        end else if (cmd_reg.sequence_req > last_seq_reg[p]) begin
                            gtot_reg[p] <= gtot_reg[p] + gap_next;
                            last_seq_reg[p] <= cmd_reg.sequence_req;
                        end else begin
                            ooo_reg[p] <= ooo_reg[p] + 32'd1;
                        end
                    end
                end
                ST_KEY: begin
                    if (st_next == ST_EMIT && vd_reg == VD_FORWARD && cmd_reg.key_track)
                        held_reg[p][cmd_reg.key_pos[KP_W-1:0]] <= cmd_reg.pressed;
                end
                default: ;
            endcase
        end
    end

    // Counter snapshot on verdicts
    logic [31:0] c_rx_reg, c_gt_reg, c_dup_reg, c_ooo_reg, c_ses_reg;
    always_ff @(posedge aclk) begin
        if (st_reg == ST_EMIT && out_free) begin
            c_rx_reg <= rx_reg[p]; c_gt_reg <= gtot_reg[p]; c_dup_reg <= dup_reg[p];
            c_ooo_reg <= ooo_reg[p]; c_ses_reg <= sesc_reg[p];
        end
    end

    assign m_valid                = ov_reg;
    assign m_result_kind          = ork_reg;
    assign m_peer                 = opeer_reg;
    assign m_release_position     = opos_reg;
    assign m_verdict              = ovd_reg;
    assign m_gap                  = ogap_reg;
    assign m_received_count       = ocnt_reg ? c_rx_reg  : '0;
    assign m_gap_total            = ocnt_reg ? c_gt_reg  : '0;
    assign m_duplicate_count      = ocnt_reg ? c_dup_reg : '0;
    assign m_reorder_count        = ocnt_reg ? c_ooo_reg : '0;
    assign m_session_change_count = ocnt_reg ? c_ses_reg : '0;
    assign m_last                 = olast_reg;
endmodule

// ----- verif/testbench.sv -----
// Testbench for split_link_rx_sequence_keystate: random and directed headers,
// predicted results compared field by field. Depends on slrsk_pkg.
`timescale 1ns / 1ps

module testbench;
    import slrsk_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [7:0]  src;
        logic [2:0]  pipe;
        logic [31:0] sid;
        logic [31:0] seqn;
        logic        app;
        logic        keyev;
        logic [7:0]  pos;
        logic        pressed;
        logic        cfg_write;  // not a header: write transport_active
        logic        cfg_val;
        logic        drain;      // not a header: wait until all results are in
    } hdr_t;

    typedef struct packed {
        logic [1:0]  rk;
        logic [2:0]  peer;
        logic [5:0]  rpos;
        logic [2:0]  verdict;
        logic [31:0] gap;
        logic [31:0] rx;
        logic [31:0] gtot;
        logic [31:0] dup;
        logic [31:0] ooo;
        logic [31:0] ses;
        logic        last;
    } res_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0, cfg_wdata = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic        s_kind = 0;
    logic [7:0]  s_wire_source = 0;
    logic [2:0]  s_pipe = 0;
    logic [31:0] s_session_tag = 0, s_sequence_req = 0;
    logic        s_is_app_event = 0, s_is_key_event = 0, s_pressed = 0;
    logic [7:0]  s_key_position = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [1:0]  m_result_kind;
    logic [2:0]  m_peer, m_verdict;
    logic [5:0]  m_release_position;
    logic [31:0] m_gap, m_received_count, m_gap_total, m_duplicate_count;
    logic [31:0] m_reorder_count, m_session_change_count;
    logic        m_last;

    split_link_rx_sequence_keystate DUT (.*);

    always #2 aclk = ~aclk;

    // Predictor state
    logic        link_active;
    logic        sess_known [SOURCES];
    logic        seq_known  [SOURCES];
    logic [31:0] cur_sess   [SOURCES];
    logic [31:0] last_seq   [SOURCES];
    logic [31:0] rx_cnt [SOURCES], gap_cnt [SOURCES], dup_cnt [SOURCES];
    logic [31:0] ooo_cnt [SOURCES], ses_cnt [SOURCES];
    logic [KEY_POSITIONS-1:0] held [SOURCES];

    hdr_t pending_hdrs[$];
    res_t expected_results[$];
    int   errors = 0, mismatches = 0, n_results = 0, n_items = 0;
    logic stim_done = 0;
    logic quiet = 0;  // no idling in the last part of the run

    function automatic res_t plain(logic [1:0] rk, int peer, int p, verdict_t v);
        res_t r;
        r = '0;
        r.rk = rk; r.peer = peer[2:0]; r.rpos = p[5:0]; r.verdict = v;
        return r;
    endfunction

    task automatic release_held(int peer);
        for (int p = 0; p < KEY_POSITIONS; p++)
            if (held[peer][p]) expected_results.push_back(plain(RK_RELEASE, peer, p, VD_FORWARD));
        held[peer] = '0;
    endtask

    // Work out the results of one accepted header
    task automatic predict_header(hdr_t h);
        int       peer;
        logic     accept;
        logic [31:0] gap;
        verdict_t v;
        res_t     r;
        accept = 1; gap = 0;
        if (h.src == 0 || h.src > SOURCES) begin
            r = plain(RK_VERDICT, 0, 0, VD_BAD_SRC); r.last = 1;
            expected_results.push_back(r);
            return;
        end
        peer = h.src - 1;
        if (h.kind) begin
            release_held(peer);
            seq_known[peer] = 0;
            r = plain(RK_DISCONNECT, peer, 0, VD_FORWARD); r.last = 1;
            expected_results.push_back(r);
            return;
        end
        if (h.pipe != h.src) begin
            r = plain(RK_VERDICT, peer, 0, VD_BAD_PIPE); r.last = 1;
            expected_results.push_back(r);
            return;
        end
        if (!sess_known[peer] || cur_sess[peer] != h.sid) begin
            if (sess_known[peer]) begin
                release_held(peer);
                ses_cnt[peer]++;
            end
            sess_known[peer] = 1; seq_known[peer] = 0; cur_sess[peer] = h.sid;
        end
        if (seq_known[peer]) begin
            if (h.seqn == last_seq[peer]) begin
                dup_cnt[peer]++; accept = 0;
            end else if (h.seqn > last_seq[peer]) begin
                gap = h.seqn - last_seq[peer] - 32'd1;
                gap_cnt[peer] += gap;
                last_seq[peer] = h.seqn;
            end else begin
                ooo_cnt[peer]++; accept = 0;
            end
        end else begin
            seq_known[peer] = 1; last_seq[peer] = h.seqn;
        end
        rx_cnt[peer]++;
        if (!accept) v = (h.seqn == last_seq[peer]) ? VD_DUP : VD_OOO;
        else if (!(h.app && link_active)) v = VD_ACCEPTED;
        else begin
            v = VD_FORWARD;
            if (h.keyev && h.pos < KEY_POSITIONS) begin
                if (h.pressed) begin
                    if (held[peer][h.pos])
                        expected_results.push_back(plain(RK_RELEASE, peer, h.pos, VD_FORWARD));
                    held[peer][h.pos] = 1;
                end else held[peer][h.pos] = 0;
            end
        end
        r = plain(RK_VERDICT, peer, 0, v);
        r.gap = gap; r.rx = rx_cnt[peer]; r.gtot = gap_cnt[peer];
        r.dup = dup_cnt[peer]; r.ooo = ooo_cnt[peer]; r.ses = ses_cnt[peer]; r.last = 1;
        expected_results.push_back(r);
    endtask

    // Driver: present headers at the falling edge, hold until transfer
    logic s_ready_q = 0;
    int   gap_left = 0;
    int   drain_wait = 0;
    logic drv_valid, drv_we;
    hdr_t cur;
    always @(negedge aclk) begin
        drv_valid = s_valid;
        drv_we    = 0;
        if (aresetn && !(s_valid && !s_ready_q)) begin
            drv_valid = 0;
            if (gap_left > 0) gap_left--;
            else if (pending_hdrs.size() > 0) begin
                cur = pending_hdrs[0];
                if (cur.drain || cur.cfg_write) begin
                    // hold until the block is idle, then wait out its latency
                    if (expected_results.size() == 0) begin
                        if (drain_wait < 60) drain_wait++;
                        else begin
                            drain_wait = 0;
                            void'(pending_hdrs.pop_front());
                            if (cur.cfg_write) begin
                                drv_we = 1; cfg_wdata <= cur.cfg_val;
                                link_active = cur.cfg_val;
                            end
                        end
                    end
                end else begin
                    void'(pending_hdrs.pop_front());
                    drv_valid = 1;
                    s_kind <= cur.kind; s_wire_source <= cur.src; s_pipe <= cur.pipe;
                    s_session_tag <= cur.sid; s_sequence_req <= cur.seqn;
                    s_is_app_event <= cur.app; s_is_key_event <= cur.keyev;
                    s_key_position <= cur.pos; s_pressed <= cur.pressed;
                    if (!quiet && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 11);
                end
            end else if (!s_valid || s_ready_q) stim_done <= 1;
        end
        s_valid <= drv_valid;
        cfg_we  <= drv_we;
    end

    // Transfer seen at the rising edge; the driver uses it at the next falling edge
    always @(posedge aclk) begin
        s_ready_q <= 0;
        if (aresetn && s_valid && s_ready) begin
            s_ready_q <= 1;
            n_items++;
            predict_header(cur);
        end
    end

    // Receiver stalls
    int stall_left = 0;
    always @(negedge aclk) begin
        if (quiet) m_ready <= 1;
        else if (stall_left > 0) begin
            stall_left--;
            m_ready <= (stall_left == 0);
        end else if ($urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(1, 11);
            m_ready <= 0;
        end else m_ready <= 1;
    end

    // Monitor: compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        res_t a, e;
        if (aresetn && m_valid && m_ready) begin
            a = {m_result_kind, m_peer, m_release_position, m_verdict, m_gap,
                 m_received_count, m_gap_total, m_duplicate_count, m_reorder_count,
                 m_session_change_count, m_last};
            n_results++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("ERROR: unexpected result %p", a);
            end else begin
                e = expected_results.pop_front();
                if (a !== e) begin
                    errors++; mismatches++;
                    if (mismatches <= 10) $display("ERROR: result %0d expected %p got %p",
                                                   n_results, e, a);
                end
            end
        end
    end

    function automatic hdr_t rand_hdr();
        hdr_t h;
        int   sel;
        h = '0;
        h.src = 8'($urandom_range(1, SOURCES));
        h.pipe = h.src[2:0];
        h.sid = 32'h100 + $urandom_range(0, 1);
        h.app = $urandom_range(0, 4) != 0;
        h.keyev = $urandom_range(0, 3) != 0;
        h.pos = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 7));
        h.pressed = $urandom_range(0, 2) != 0;
        sel = $urandom_range(0, 19);
        if (sel == 0) h.kind = 1;
        else if (sel == 1) h.src = ($urandom_range(0, 1)) ? 8'd0 : 8'($urandom_range(3, 255));
        else if (sel == 2) h.pipe = 3'($urandom_range(0, 7));
        else if (sel == 3) h.sid = $urandom;
        return h;
    endfunction

    function automatic hdr_t mk(logic kind, int src, int pipe, logic [31:0] sid,
                                logic [31:0] seqn, logic app, logic keyev, int pos,
                                logic pr);
        hdr_t h;
        h = '0;
        h.kind = kind; h.src = 8'(src); h.pipe = 3'(pipe); h.sid = sid; h.seqn = seqn;
        h.app = app; h.keyev = keyev; h.pos = 8'(pos); h.pressed = pr;
        return h;
    endfunction

    function automatic hdr_t ctl(logic w, logic v);
        hdr_t h;
        h = '0;
        h.cfg_write = w; h.cfg_val = v; h.drain = !w;
        return h;
    endfunction

    logic [31:0] seq_ctr [SOURCES];
    initial begin
        hdr_t h;
        link_active = 1;
        for (int i = 0; i < SOURCES; i++) begin
            sess_known[i] = 0; seq_known[i] = 0; cur_sess[i] = 0; last_seq[i] = 0;
            rx_cnt[i] = 0; gap_cnt[i] = 0; dup_cnt[i] = 0; ooo_cnt[i] = 0; ses_cnt[i] = 0;
            held[i] = '0; seq_ctr[i] = 0;
        end
        // Directed: bad sources, wrong pipe, keys, repeats, gaps, sessions, disconnect
        pending_hdrs.push_back(ctl(1, 1));
        pending_hdrs.push_back(mk(0, 0, 0, 0, 0, 1, 1, 0, 1));
        pending_hdrs.push_back(mk(1, 255, 7, '1, '1, 1, 1, 255, 1));
        pending_hdrs.push_back(mk(0, 1, 2, 5, 5, 1, 1, 3, 1));
        pending_hdrs.push_back(mk(0, 1, 1, '1, 0, 1, 1, 0, 1));
        pending_hdrs.push_back(mk(0, 1, 1, '1, 1, 1, 1, 31, 1));
        pending_hdrs.push_back(mk(0, 1, 1, '1, 2, 1, 1, 31, 1));
        pending_hdrs.push_back(mk(0, 1, 1, '1, 2, 1, 1, 5, 1));
        pending_hdrs.push_back(mk(0, 1, 1, '1, 1, 1, 1, 5, 1));
        pending_hdrs.push_back(mk(0, 1, 1, '1, '1, 1, 1, 32, 1));
        pending_hdrs.push_back(mk(0, 1, 1, '1, 'h7fff_ffff, 1, 1, 200, 0));
        pending_hdrs.push_back(mk(0, 1, 1, 0, 9, 0, 1, 7, 1));
        pending_hdrs.push_back(mk(0, 2, 2, 'h8000_0000, 'h8000_0000, 1, 0, 9, 1));
        pending_hdrs.push_back(mk(0, 2, 2, 'h8000_0000, 'h8000_0003, 1, 1, 4, 1));
        pending_hdrs.push_back(mk(0, 2, 2, 'h8000_0000, 'h8000_0004, 1, 1, 4, 0));
        pending_hdrs.push_back(mk(0, 2, 2, 'h8000_0000, 'h8000_0005, 1, 1, 6, 1));
        pending_hdrs.push_back(mk(1, 2, 0, 0, 0, 0, 0, 0, 0));
        pending_hdrs.push_back(mk(0, 2, 2, 'h8000_0000, 1, 1, 1, 6, 1));
        pending_hdrs.push_back(ctl(0, 0));
        pending_hdrs.push_back(ctl(1, 0));
        pending_hdrs.push_back(mk(0, 2, 2, 'h8000_0000, 2, 1, 1, 6, 1));
        pending_hdrs.push_back(ctl(1, 1));
        // Random: mostly in-order runs per peer with small gaps, plus noise
        for (int i = 0; i < 250; i++) begin
            h = rand_hdr();
            if (h.src >= 1 && h.src <= SOURCES) begin
                case ($urandom_range(0, 9))
                    0: h.seqn = seq_ctr[h.src - 1];
                    1: h.seqn = seq_ctr[h.src - 1] - $urandom_range(1, 3);
                    2: h.seqn = $urandom;
                    default: begin
                        seq_ctr[h.src - 1] += $urandom_range(1, 3);
                        h.seqn = seq_ctr[h.src - 1];
                    end
                endcase
            end else h.seqn = $urandom;
            if (i % 32 == 0) h.pos[7] = 1'b1;
            pending_hdrs.push_back(h);
            if (i == 80) pending_hdrs.push_back(ctl(1, 0));
            if (i == 110) pending_hdrs.push_back(ctl(1, 1));
            if (i == 150) pending_hdrs.push_back(ctl(0, 0));
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        wait (pending_hdrs.size() < 40);
        quiet = 1;
        wait (stim_done && expected_results.size() == 0);
        repeat (100) @(posedge aclk);
        $display("Ran %0d headers and %0d results: bad sources, wrong pipes, gaps,", n_items,
                 n_results);
        $display("duplicates, reorders, session changes, disconnects, both link settings.");
        if (errors == 0 && expected_results.size() == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

    // Run limit
    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
